/* rtl/bksm_pkg.sv */
package bksm_pkg;

	localparam int MAX_TOKENS  = 32;
	localparam int TOKEN_LEN   = 32;
	localparam int QUERY_CHARS = 256;

	localparam int SLOT_W = $clog2(MAX_TOKENS);
	localparam int TV_W   = $clog2(MAX_TOKENS + 1);
	localparam int POS_W  = $clog2(TOKEN_LEN);
	localparam int LEN_W  = $clog2(TOKEN_LEN + 1);
	localparam int QS_W   = $clog2(QUERY_CHARS + 1);

	localparam logic [7:0] CH_ESCAPE  = 8'h26;
	localparam logic [7:0] CH_INCLUDE = 8'h2B;
	localparam logic [7:0] CH_EXCLUDE = 8'h2D;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef enum logic [1:0] {
		MARK_PLAIN    = 2'd0,
		MARK_REQUIRED = 2'd1,
		MARK_EXCLUDED = 2'd2
	} mark_t;

	typedef enum logic {
		CMD_QUERY  = 1'b0,
		CMD_BUFFER = 1'b1
	} cmd_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        matched;
		logic        rejected;
		logic [5:0]  token_count;
		logic [31:0] found_mask;
	} result_t;

	// token store update and byte broadcast for the cell row
	typedef struct packed {
		logic              ch_en;
		logic [SLOT_W-1:0] ch_slot;
		logic [POS_W-1:0]  ch_pos;
		logic [7:0]        ch_val;
		logic              len_en;
		logic [SLOT_W-1:0] len_slot;
		logic [LEN_W-1:0]  len_val;
		logic              mark_en;
		logic [SLOT_W-1:0] mark_slot;
		logic [1:0]        mark_val;
		logic              byte_en;
		logic              byte_last;
		logic [7:0]        byte_val;
		logic [TV_W-1:0]   tokens;
	} cell_ctl_t;

	typedef struct packed {
		logic rej;
		logic ok;
	} verdict_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

endpackage

/* rtl/bksm_cell.sv */
module bksm_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bksm_pkg::SLOT_W-1:0]      slot,
	input  bksm_pkg::cell_ctl_t              ctl,
	input  bksm_pkg::verdict_t               vin,
	output bksm_pkg::verdict_t               vout,
	output logic                             found
);

	logic [7:0]                      ch_q [bksm_pkg::TOKEN_LEN];
	logic [7:0]                      ch_d [bksm_pkg::TOKEN_LEN];
	logic [bksm_pkg::LEN_W-1:0]      len_q, len_d;
	logic [1:0]                      mark_q, mark_d;
	logic [bksm_pkg::TOKEN_LEN-1:0]  act_q, act_d;
	logic                            found_q, found_d, hit, active;
	logic [bksm_pkg::LEN_W-1:0]      len_m1;

	// token contents as they stand after this cycle's writes
	always_comb begin
		for (int k = 0; k < bksm_pkg::TOKEN_LEN; k++) begin
			ch_d[k] = (ctl.ch_en && ctl.ch_slot == slot && ctl.ch_pos == k[bksm_pkg::POS_W-1:0])
				? ctl.ch_val : ch_q[k];
		end
		len_d  = (ctl.len_en && ctl.len_slot == slot) ? ctl.len_val : len_q;
		mark_d = (ctl.mark_en && ctl.mark_slot == slot) ? ctl.mark_val : mark_q;
	end

	// shift-and prefix tracking against the broadcast byte
	always_comb begin
		for (int k = 0; k < bksm_pkg::TOKEN_LEN; k++) begin
			act_d[k] = ((k == 0) ? 1'b1 : act_q[(k == 0) ? 0 : k - 1]) &&
				(bksm_pkg::fold(ch_d[k]) == bksm_pkg::fold(ctl.byte_val));
		end
		len_m1  = len_d - 1'b1;
		active  = {1'b0, slot} < ctl.tokens;
		hit     = active && len_d != '0 && act_d[len_m1[bksm_pkg::POS_W-1:0]];
		found_d = found_q | (ctl.byte_en & hit);
	end

	// verdict handed down the row
	always_comb begin
		vout.rej = vin.rej | (active && ((found_d && mark_d == bksm_pkg::MARK_EXCLUDED) ||
			(!found_d && mark_d == bksm_pkg::MARK_REQUIRED)));
		vout.ok  = vin.ok | (active && found_d && mark_d != bksm_pkg::MARK_EXCLUDED);
		found    = found_d;
	end

	// token characters
	always_ff @(posedge clk) begin
		for (int k = 0; k < bksm_pkg::TOKEN_LEN; k++) begin
			ch_q[k] <= ch_d[k];
		end
	end

	// token length, mark and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			mark_q  <= '0;
			act_q   <= '0;
			found_q <= 1'b0;
		end else begin
			len_q  <= len_d;
			mark_q <= mark_d;
			if (ctl.byte_en) begin
				act_q   <= ctl.byte_last ? '0 : act_d;
				found_q <= ctl.byte_last ? 1'b0 : found_d;
			end
		end
	end

endmodule

/* rtl/boolean_keyword_stream_matcher.sv */
// Boolean keyword matcher: send query characters (command 0) first, then buffer
// bytes (command 1). Every request is taken one per clock unless the input stalls; all
// token slots are compared against each byte at once in a row of 32 cells,
// each holding one token and its partial-match bits. The result for a buffer
// is registered and appears the cycle after its last byte; the input stalls
// only when another last byte arrives while that result is still waiting.
module boolean_keyword_stream_matcher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bksm_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output bksm_pkg::result_t   result
);

	logic [bksm_pkg::QS_W-1:0]   qs_q, qs_d;
	logic                        done_q, done_d;
	logic [bksm_pkg::SLOT_W-1:0] slot_q, slot_d;
	logic [bksm_pkg::LEN_W-1:0]  plen_q, plen_d;
	logic                        inq_q, inq_d, esc_q, esc_d;
	logic [bksm_pkg::TV_W-1:0]   tv_q, tv_d;
	logic                        accept, fin, app_en, parse;
	logic [7:0]                  app_c;
	bksm_pkg::cell_ctl_t         ctl;
	bksm_pkg::verdict_t          vchain [bksm_pkg::MAX_TOKENS+1];
	logic [bksm_pkg::MAX_TOKENS-1:0] found;
	logic                        out_valid_q;
	bksm_pkg::result_t           out_q;

	assign accept     = item_valid && !item_stall;
	assign item_stall = out_valid_q && result_stall && item.command == bksm_pkg::CMD_BUFFER
		&& item.last;

	// query parser
	always_comb begin
		qs_d   = qs_q;
		done_d = done_q;
		slot_d = slot_q;
		plen_d = plen_q;
		inq_d  = inq_q;
		esc_d  = esc_q;
		tv_d   = tv_q;
		fin    = 1'b0;
		parse  = 1'b0;
		app_en = 1'b0;
		app_c  = item.data;
		ctl    = '0;
		if (accept && item.command == bksm_pkg::CMD_QUERY && !done_q) begin
			if (item.data == 8'h00) begin
				fin = 1'b1;
			end else begin
				if (qs_q < bksm_pkg::QS_W'(bksm_pkg::QUERY_CHARS)) begin
					qs_d  = qs_q + 1'b1;
					parse = 1'b1;
				end
				fin = item.last;
			end
		end
		if (accept && item.command == bksm_pkg::CMD_BUFFER && !done_q) begin
			fin = 1'b1;
		end
		if (parse) begin
			priority if (esc_q) begin
				app_en = 1'b1;
				esc_d  = 1'b0;
			end else if (item.data == bksm_pkg::CH_ESCAPE) begin
				esc_d = 1'b1;
			end else if (item.data == bksm_pkg::CH_QUOTE) begin
				inq_d = !inq_q;
			end else if (inq_q) begin
				app_en = 1'b1;
			end else if (plen_q == '0 && item.data == bksm_pkg::CH_INCLUDE) begin
				ctl.mark_en   = 1'b1;
				ctl.mark_slot = slot_q;
				ctl.mark_val  = bksm_pkg::MARK_REQUIRED;
			end else if (plen_q == '0 && item.data == bksm_pkg::CH_EXCLUDE) begin
				ctl.mark_en   = 1'b1;
				ctl.mark_slot = slot_q;
				ctl.mark_val  = bksm_pkg::MARK_EXCLUDED;
			end else if (item.data == bksm_pkg::CH_SPACE) begin
				if (plen_q != '0) begin
					if (slot_q != bksm_pkg::SLOT_W'(bksm_pkg::MAX_TOKENS - 1)) begin
						slot_d = slot_q + 1'b1;
					end else begin
						ctl.len_en   = 1'b1;
						ctl.len_slot = slot_q;
						ctl.len_val  = '0;
					end
					plen_d = '0;
				end
				ctl.mark_en   = 1'b1;
				ctl.mark_slot = slot_d;
				ctl.mark_val  = bksm_pkg::MARK_PLAIN;
			end else begin
				app_en = 1'b1;
			end
		end
		// a dangling escape at the end of the query stands for itself
		if (fin && esc_d) begin
			app_en = 1'b1;
			app_c  = bksm_pkg::CH_ESCAPE;
			esc_d  = 1'b0;
		end
		if (app_en && plen_d < bksm_pkg::LEN_W'(bksm_pkg::TOKEN_LEN)) begin
			ctl.ch_en    = 1'b1;
			ctl.ch_slot  = slot_d;
			ctl.ch_pos   = plen_d[bksm_pkg::POS_W-1:0];
			ctl.ch_val   = app_c;
			plen_d       = plen_d + 1'b1;
			ctl.len_en   = 1'b1;
			ctl.len_slot = slot_d;
			ctl.len_val  = plen_d;
		end
		if (fin) begin
			done_d = 1'b1;
			tv_d   = bksm_pkg::TV_W'(slot_d) + bksm_pkg::TV_W'(plen_d != '0);
		end
		ctl.tokens    = tv_d;
		ctl.byte_en   = accept && item.command == bksm_pkg::CMD_BUFFER;
		ctl.byte_last = item.last;
		ctl.byte_val  = item.data;
	end

	// row of token cells
	assign vchain[0] = '0;
	for (genvar t = 0; t < bksm_pkg::MAX_TOKENS; t++) begin : g_cell
		bksm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.slot   (bksm_pkg::SLOT_W'(t)),
			.ctl    (ctl),
			.vin    (vchain[t]),
			.vout   (vchain[t+1]),
			.found  (found[t])
		);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_q   <= '0;
			done_q <= 1'b0;
			slot_q <= '0;
			plen_q <= '0;
			inq_q  <= 1'b0;
			esc_q  <= 1'b0;
			tv_q   <= '0;
		end else begin
			qs_q   <= qs_d;
			done_q <= done_d;
			slot_q <= slot_d;
			plen_q <= plen_d;
			inq_q  <= inq_d;
			esc_q  <= esc_d;
			tv_q   <= tv_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.byte_en && item.last) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.byte_en && item.last) begin
			out_q.matched     <= !vchain[bksm_pkg::MAX_TOKENS].rej &&
				vchain[bksm_pkg::MAX_TOKENS].ok;
			out_q.rejected    <= vchain[bksm_pkg::MAX_TOKENS].rej;
			out_q.token_count <= 6'(tv_d);
			out_q.found_mask  <= 32'(found);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> out_valid_q) else $error("stall without pending result");
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command == bksm_pkg::CMD_BUFFER && item.last) |=> result_valid)
		else $error("final byte gave no result");
	a_verdict_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.matched && result.rejected))
		else $error("matched and rejected together");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tv_q <= bksm_pkg::TV_W'(bksm_pkg::MAX_TOKENS)) else $error("token count overflow");

endmodule

/* verif/boolean_keyword_stream_matcher_tb.sv */
`timescale 1ns / 100ps

module boolean_keyword_stream_matcher_tb;

	localparam int WATCHDOG_LIMIT = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	bksm_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	bksm_pkg::result_t result;

	boolean_keyword_stream_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #10 clk = ~clk;

	// shadow copy of the matcher state
	logic [7:0]      tok_ch [bksm_pkg::MAX_TOKENS][bksm_pkg::TOKEN_LEN];
	int              tok_len [bksm_pkg::MAX_TOKENS];
	bksm_pkg::mark_t tok_mark [bksm_pkg::MAX_TOKENS];
	logic [7:0]      window [bksm_pkg::TOKEN_LEN];
	int              query_seen, cur_slot, cur_len, token_total, window_fill;
	bit              query_closed, quoting, escaping;
	logic [31:0]     hit_bits;

	bksm_pkg::item_t   request_q [$];
	bksm_pkg::result_t verdict_q [$];
	bksm_pkg::result_t last_seen;
	int      idle_pct = 0, stall_pct = 0;
	int      failures = 0, requests_done = 0, verdicts_done = 0, watchdog = 0;
	bit      seen_match = 0, seen_reject = 0;

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	function automatic void store_char(logic [7:0] c);
		if (cur_len < bksm_pkg::TOKEN_LEN) begin
			tok_ch[cur_slot][cur_len] = c;
			cur_len++;
			tok_len[cur_slot] = cur_len;
		end
	endfunction

	// tokenizer for one query character
	function automatic void parse_query_char(logic [7:0] c);
		if (escaping) begin
			store_char(c);
			escaping = 0;
		end else if (c == bksm_pkg::CH_ESCAPE) begin
			escaping = 1;
		end else if (c == bksm_pkg::CH_QUOTE) begin
			quoting = !quoting;
		end else if (quoting) begin
			store_char(c);
		end else if (cur_len == 0 && c == bksm_pkg::CH_INCLUDE) begin
			tok_mark[cur_slot] = bksm_pkg::MARK_REQUIRED;
		end else if (cur_len == 0 && c == bksm_pkg::CH_EXCLUDE) begin
			tok_mark[cur_slot] = bksm_pkg::MARK_EXCLUDED;
		end else if (c == bksm_pkg::CH_SPACE) begin
			if (cur_len != 0) begin
				if (cur_slot < bksm_pkg::MAX_TOKENS - 1)
					cur_slot++;
				else
					tok_len[cur_slot] = 0;
				cur_len = 0;
			end
			tok_mark[cur_slot] = bksm_pkg::MARK_PLAIN;
		end else begin
			store_char(c);
		end
	endfunction

	function automatic void close_query();
		if (escaping) begin
			store_char(bksm_pkg::CH_ESCAPE);
			escaping = 0;
		end
		query_closed = 1;
		token_total = cur_slot + (cur_len > 0 ? 1 : 0);
	endfunction

	// shift a byte into the window and test every token ending there
	function automatic void scan_byte(logic [7:0] b);
		bit hit;
		for (int i = bksm_pkg::TOKEN_LEN - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = lower(b);
		if (window_fill < bksm_pkg::TOKEN_LEN)
			window_fill++;
		for (int t = 0; t < token_total; t++) begin
			if (tok_len[t] == 0 || tok_len[t] > window_fill)
				continue;
			hit = 1;
			for (int k = 0; k < tok_len[t]; k++)
				if (lower(tok_ch[t][k]) != window[tok_len[t]-1-k])
					hit = 0;
			if (hit)
				hit_bits[t] = 1'b1;
		end
	endfunction

	function automatic void predict_request(bksm_pkg::item_t r);
		bksm_pkg::result_t v;
		bit ok, rej;
		if (r.command == bksm_pkg::CMD_QUERY) begin
			if (query_closed)
				return;
			if (r.data == 8'd0) begin
				close_query();
				return;
			end
			if (query_seen < bksm_pkg::QUERY_CHARS) begin
				query_seen++;
				parse_query_char(r.data);
			end
			if (r.last)
				close_query();
			return;
		end
		if (!query_closed)
			close_query();
		scan_byte(r.data);
		if (!r.last)
			return;
		ok = 0;
		rej = 0;
		for (int t = 0; t < token_total && !rej; t++) begin
			if (hit_bits[t]) begin
				if (tok_mark[t] == bksm_pkg::MARK_EXCLUDED)
					rej = 1;
				else
					ok = 1;
			end else if (tok_mark[t] == bksm_pkg::MARK_REQUIRED) begin
				rej = 1;
			end
		end
		v.matched = !rej && ok;
		v.rejected = rej;
		v.token_count = 6'(token_total);
		v.found_mask = hit_bits;
		verdict_q.push_back(v);
		for (int i = 0; i < bksm_pkg::TOKEN_LEN; i++)
			window[i] = 8'd0;
		window_fill = 0;
		hit_bits = '0;
	endfunction

	// drive requests, apply backpressure, predict and check
	always @(posedge clk) begin
		bksm_pkg::result_t exp_v;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (item_valid && !item_stall) begin
				predict_request(item);
				requests_done++;
				moved = 1;
			end
			if (result_valid && !result_stall) begin
				moved = 1;
				verdicts_done++;
				last_seen = result;
				if (verdict_q.size() == 0) begin
					$error("unexpected result %p", result);
					failures++;
				end else begin
					exp_v = verdict_q.pop_front();
					seen_match |= exp_v.matched;
					seen_reject |= exp_v.rejected;
					if (result.matched !== exp_v.matched) begin
						$error("matched: expected %0d actual %0d", exp_v.matched,
							result.matched);
						failures++;
					end
					if (result.rejected !== exp_v.rejected) begin
						$error("rejected: expected %0d actual %0d", exp_v.rejected,
							result.rejected);
						failures++;
					end
					if (result.token_count !== exp_v.token_count) begin
						$error("token_count: expected %0d actual %0d",
							exp_v.token_count, result.token_count);
						failures++;
					end
					if (result.found_mask !== exp_v.found_mask) begin
						$error("found_mask: expected %h actual %h", exp_v.found_mask,
							result.found_mask);
						failures++;
					end
				end
			end
			if (moved)
				watchdog = 0;
			else
				watchdog++;
			if (!item_valid || !item_stall) begin
				if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					item_valid <= 1'b1;
					item <= request_q.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("boolean_keyword_stream_matcher_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_query(string s);
		bksm_pkg::item_t r;
		for (int i = 0; i < s.len(); i++) begin
			r.command = bksm_pkg::CMD_QUERY;
			r.data = s[i];
			r.last = 1'b0;
			request_q.push_back(r);
		end
	endtask

	task automatic send_buffer(string s);
		bksm_pkg::item_t r;
		for (int i = 0; i < s.len(); i++) begin
			r.command = bksm_pkg::CMD_BUFFER;
			r.data = s[i];
			r.last = (i == s.len() - 1);
			request_q.push_back(r);
		end
	endtask

	// buffer built from token text with random case, random bytes and stray query chars
	task automatic send_random_buffer(int max_len);
		bksm_pkg::item_t r;
		logic [7:0] bytes [$];
		int t;
		while (bytes.size() < max_len) begin
			if ($urandom_range(1) && token_total > 0) begin
				t = $urandom_range(token_total - 1);
				for (int k = 0; k < tok_len[t]; k++) begin
					bytes.push_back(tok_ch[t][k]);
					if (lower(tok_ch[t][k]) != tok_ch[t][k] || (tok_ch[t][k] >= "a" &&
						tok_ch[t][k] <= "z"))
						if ($urandom_range(1))
							bytes[$] = bytes[$] ^ 8'h20;
				end
			end else begin
				repeat ($urandom_range(1, 3))
					bytes.push_back(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(3) == 0)
			bytes = bytes[0:$urandom_range(bytes.size() - 1)];
		foreach (bytes[i]) begin
			if ($urandom_range(29) == 0) begin
				r.command = bksm_pkg::CMD_QUERY;
				r.data = 8'($urandom_range(255));
				r.last = 1'($urandom_range(1));
				request_q.push_back(r);
			end
			r.command = bksm_pkg::CMD_BUFFER;
			r.data = bytes[i];
			r.last = (i == bytes.size() - 1);
			request_q.push_back(r);
		end
	endtask

	// wait on the falling edge so every update of the rising edge has settled
	task automatic drain();
		do
			@(negedge clk);
		while (request_q.size() > 0 || item_valid || verdict_q.size() > 0);
	endtask

	typedef struct {
		string text;
		bit    typed;
		bit    matched;
		bit    rejected;
	} buffer_row_t;

	initial begin
		buffer_row_t rows [$];
		string q;
		int n;
		bksm_pkg::item_t r;

		query_seen = 0; cur_slot = 0; cur_len = 0; token_total = 0; window_fill = 0;
		query_closed = 0; quoting = 0; escaping = 0; hit_bits = '0;
		for (int t = 0; t < bksm_pkg::MAX_TOKENS; t++) begin
			tok_len[t] = 0;
			tok_mark[t] = bksm_pkg::MARK_PLAIN;
			for (int k = 0; k < bksm_pkg::TOKEN_LEN; k++)
				tok_ch[t][k] = 8'd0;
		end
		for (int i = 0; i < bksm_pkg::TOKEN_LEN; i++)
			window[i] = 8'd0;

		// required, excluded, flag cleared by a space, quoted text, escapes,
		// upper case, an overlong token, then enough tokens to overflow the slots
		q = {"+ab -cd + fr \"Q t\" &\"q &+p &-m && &  AbC ",
			"abcdefghijklmnopqrstuvwxyz0123456789WXYZ "};
		n = 0;
		while (q.len() < 250) begin
			q = {q, $sformatf("t%0d ", n)};
			n++;
		end
		while (q.len() < 255)
			q = {q, "x"};
		// escape as the last counted character, then ignored characters
		q = {q, "&ignored+-\"&"};
		send_query(q);
		r.command = bksm_pkg::CMD_QUERY;
		r.data = 8'd0;
		r.last = 1'b0;
		request_q.push_back(r);

		rows.push_back('{"zz", 1, 0, 1});
		rows.push_back('{"ab cd", 1, 0, 1});
		rows.push_back('{"xAB", 0, 0, 0});
		rows.push_back('{"ab fr", 0, 0, 0});
		rows.push_back('{"ab q t", 0, 0, 0});
		rows.push_back('{"ab \"q +p -m &", 0, 0, 0});
		rows.push_back('{"abABCabc", 0, 0, 0});
		rows.push_back('{"ab abcdefghijklmnopqrstuvwxyz012345", 0, 0, 0});
		rows.push_back('{"ABCDEFGHIJKLMNOPQRSTUVWXYZ012345ab", 0, 0, 0});
		rows.push_back('{"ab t0 t1 t29 t30 t40", 0, 0, 0});
		rows.push_back('{"ab xxxx&", 0, 0, 0});
		rows.push_back('{"a", 0, 0, 0});
		rows.push_back('{"\377\200ab\177", 0, 0, 0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, no idling, each buffer fully answered before the next
		foreach (rows[i]) begin
			send_buffer(rows[i].text);
			drain();
			if (rows[i].typed) begin
				// missing required or present excluded token gives these directly
				if (last_seen.matched !== rows[i].matched) begin
					$error("matched: expected %0d actual %0d", rows[i].matched,
						last_seen.matched);
					failures++;
				end
				if (last_seen.rejected !== rows[i].rejected) begin
					$error("rejected: expected %0d actual %0d", rows[i].rejected,
						last_seen.rejected);
					failures++;
				end
			end
		end

		// sender holds off until every verdict is back
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			repeat (20)
				send_random_buffer($urandom_range(9) == 0 ? 70 : $urandom_range(1, 24));
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d requests and %0d buffer verdicts (%0d tokens parsed)",
			requests_done, verdicts_done, token_total);
		$display("verdict kinds seen: accepted=%0d rejected=%0d", seen_match, seen_reject);
		if (failures == 0)
			$display("boolean_keyword_stream_matcher_tb: PASS");
		else
			$display("boolean_keyword_stream_matcher_tb: FAIL");
		$finish;
	end

endmodule
